// ----- src/extended_gcd_bezout_macros.svh -----
// assertion macros used by the extended gcd core (egcd_core)
// no dependencies; each macro expects clk and rst in the including scope
`ifndef EXTENDED_GCD_BEZOUT_MACROS_SVH
`define EXTENDED_GCD_BEZOUT_MACROS_SVH

// same-cycle implication, checked out of reset
`define EGCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EGCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/egcd_pkg.sv -----
// widths, sequencer states and status type for the extended gcd block
// no dependencies
package egcd_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int MAG_WIDTH   = DATA_WIDTH - 1;
  localparam int SHIFT_WIDTH = $clog2(MAG_WIDTH);

  localparam logic [DATA_WIDTH-1:0] COEF_ONE  = DATA_WIDTH'(1);
  localparam logic [DATA_WIDTH-1:0] COEF_ZERO = '0;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_REDUCE = 4'b0100,
    ST_HOLD   = 4'b1000
  } egcd_state_t;

  // core status seen by the top level
  typedef struct packed {
    logic idle;
    logic hold;
  } egcd_stat_t;

endpackage

// ----- src/egcd_core.sv -----
// iterative extended euclid core: one shared compare/subtract unit
// depends on egcd_pkg and extended_gcd_bezout_macros.svh
`include "extended_gcd_bezout_macros.svh"

module egcd_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [egcd_pkg::MAG_WIDTH-1:0]       a,
  input  logic [egcd_pkg::MAG_WIDTH-1:0]       b,
  input  logic                                 take,
  output egcd_pkg::egcd_stat_t                 stat,
  output logic [egcd_pkg::MAG_WIDTH-1:0]       res_gcd,
  output logic [egcd_pkg::DATA_WIDTH-1:0]      res_s,
  output logic [egcd_pkg::DATA_WIDTH-1:0]      res_t
);
  import egcd_pkg::*;

  egcd_state_t             state, state_next;
  logic [MAG_WIDTH-1:0]    rp, rp_next, rc, rc_next;
  logic [DATA_WIDTH-1:0]   sp, sp_next, sc, sc_next;
  logic [DATA_WIDTH-1:0]   tp, tp_next, tc, tc_next;
  logic [DATA_WIDTH-1:0]   d, d_next;
  logic [SHIFT_WIDTH-1:0]  k, k_next;

  logic                    ge, grow;
  logic [DATA_WIDTH-1:0]   d_up;
  logic [MAG_WIDTH-1:0]    rp_red;
  logic [DATA_WIDTH-1:0]   sp_red, tp_red;

  // shared unit: scaled divisor compare, conditional subtract of r, s, t
  assign d_up   = {d[DATA_WIDTH-2:0], 1'b0};
  assign grow   = d_up <= {1'b0, rp};
  assign ge     = {1'b0, rp} >= d;
  assign rp_red = ge ? rp - d[MAG_WIDTH-1:0] : rp;
  assign sp_red = ge ? sp - (sc << k) : sp;
  assign tp_red = ge ? tp - (tc << k) : tp;

  // sequencer: scan up the divisor shift, then reduce one quotient bit a cycle
  always_comb begin
    state_next = state;
    rp_next    = rp;
    rc_next    = rc;
    sp_next    = sp;
    sc_next    = sc;
    tp_next    = tp;
    tc_next    = tc;
    d_next     = d;
    k_next     = k;
    case (state)
      ST_IDLE: begin
        if (start) begin
          rp_next    = a;
          rc_next    = b;
          sp_next    = COEF_ONE;
          sc_next    = COEF_ZERO;
          tp_next    = COEF_ZERO;
          tc_next    = COEF_ONE;
          d_next     = {1'b0, b};
          k_next     = '0;
          state_next = (b == '0) ? ST_HOLD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (grow) begin
          d_next = d_up;
          k_next = k + 1'b1;
        end else begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (k != '0) begin
          rp_next = rp_red;
          sp_next = sp_red;
          tp_next = tp_red;
          d_next  = d >> 1;
          k_next  = k - 1'b1;
        end else begin
          // quotient done: rotate the remainder and coefficient pairs
          rp_next    = rc;
          rc_next    = rp_red;
          sp_next    = sc;
          sc_next    = sp_red;
          tp_next    = tc;
          tc_next    = tp_red;
          d_next     = {1'b0, rp_red};
          k_next     = '0;
          state_next = (rp_red == '0) ? ST_HOLD : ST_SCAN;
        end
      end
      ST_HOLD: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rp <= rp_next;
    rc <= rc_next;
    sp <= sp_next;
    sc <= sc_next;
    tp <= tp_next;
    tc <= tc_next;
    d  <= d_next;
    k  <= k_next;
  end

  assign stat.idle = (state == ST_IDLE);
  assign stat.hold = (state == ST_HOLD);
  assign res_gcd   = rp;
  assign res_s     = sp;
  assign res_t     = tp;

  `EGCD_ASSERT_NOW(a_divisor_nonzero, (state == ST_SCAN) || (state == ST_REDUCE), (d != '0) && (rc != '0), "working divisor is zero")
  `EGCD_ASSERT_NEXT(a_reduce_countdown, (state == ST_REDUCE) && (k != '0), (state == ST_REDUCE) && (k == $past(k) - 1'b1), "reduce shift did not count down")
  `EGCD_ASSERT_NEXT(a_hold_until_taken, (state == ST_HOLD) && !take, (state == ST_HOLD) && $stable(rp) && $stable(sp) && $stable(tp), "result left hold before taken")

endmodule

// ----- src/extended_gcd_bezout.sv -----
// extended gcd block: input beat of two operands, result beat of gcd and
// bezout coefficients s, t with a*s + b*t = gcd
//
// usage
//   req channel: req_valid/req_stall carry first_value (a), second_value (b)
//   rsp channel: rsp_valid/rsp_stall carry divisor, coeff_first, coeff_second
//   a beat moves at a rising edge with valid high and stall low
//   one operand pair is processed at a time; req_stall stays high from the
//   accepted beat until the core has handed its result to the output register
//   sequence: b zero sends the core straight to hold; otherwise each quotient
//   step scans the divisor shift up, then reduces it one quotient bit at a
//   time in the compare/subtract loop of egcd_core; from hold the result
//   moves to the output register
//   throughput: the next request can be accepted in the cycle rsp_valid rises
//   result: b zero gives (a, 1, 0); a zero and b nonzero gives (b, 0, 1)
//   stall: a stalled result holds in the output register; the core keeps the
//   next result until the register frees, and the next request waits for that
//   reset: synchronous, active high; drops rsp_valid and returns to idle
// depends on egcd_pkg and egcd_core
module extended_gcd_bezout (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  output logic                                   req_stall,
  input  logic [egcd_pkg::MAG_WIDTH-1:0]         first_value,
  input  logic [egcd_pkg::MAG_WIDTH-1:0]         second_value,
  output logic                                   rsp_valid,
  input  logic                                   rsp_stall,
  output logic [egcd_pkg::MAG_WIDTH-1:0]         divisor,
  output logic signed [egcd_pkg::DATA_WIDTH-1:0] coeff_first,
  output logic signed [egcd_pkg::DATA_WIDTH-1:0] coeff_second
);
  import egcd_pkg::*;

  egcd_stat_t             stat;
  logic                   start, load;
  logic [MAG_WIDTH-1:0]   res_gcd;
  logic [DATA_WIDTH-1:0]  res_s, res_t;

  // input handshake
  assign req_stall = !stat.idle;
  assign start     = req_valid && !req_stall;

  // move the finished result once the output register is free
  assign load = stat.hold && (!rsp_valid || !rsp_stall);

  egcd_core u_core (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .a       (first_value),
    .b       (second_value),
    .take    (load),
    .stat    (stat),
    .res_gcd (res_gcd),
    .res_s   (res_s),
    .res_t   (res_t)
  );

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      divisor      <= res_gcd;
      coeff_first  <= $signed(res_s);
      coeff_second <= $signed(res_t);
    end
  end

endmodule
